// ----- src/bts_pkg.sv -----
package bts_pkg;

  localparam int CFG_W = 11;
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int ROW_W = 11;
  localparam int IDX_W = 2;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_SIZE = 4;
  localparam int RESET_SIZE = 1024;
  localparam int MIN_NEIGHBORS = 2;
  localparam int MAX_NEIGHBORS = 6;
  localparam int WIN_CELLS = 2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SUB_PASS     = 2'd2
  } cfg_reg_t;

  typedef logic [2:0] col_bits_t;

  typedef struct packed {
    logic kind;
    logic pixel;
  } in_word_t;

  typedef struct packed {
    logic out_valid;
    logic out_pixel;
    logic out_last;
    logic frame_changed;
  } out_word_t;

  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(MIN_SIZE)) begin
      r = CFG_W'(MIN_SIZE);
    end else if (int'(v) > int'(hi)) begin
      r = CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // window bits: 0..2 west column, 3..5 centre column, 6..8 east column;
  // within a column: north, middle, south
  function automatic logic should_clear(logic [8:0] w, logic pass);
    logic [8:0] ring;
    logic [3:0] trans;
    logic [3:0] cnt;
    logic p1;
    logic p2;
    ring = {w[3], w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
    trans = 4'd0;
    cnt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (!ring[k] && ring[k+1]) begin
        trans = trans + 4'd1;
      end
      cnt = cnt + {3'b000, ring[k]};
    end
    if (!pass) begin
      p1 = w[3] & w[7] & w[5];
      p2 = w[7] & w[5] & w[1];
    end else begin
      p1 = w[3] & w[7] & w[1];
      p2 = w[3] & w[5] & w[1];
    end
    return w[4] && (trans == 4'd1) && (cnt >= 4'(MIN_NEIGHBORS)) &&
           (cnt <= 4'(MAX_NEIGHBORS)) && !p1 && !p2;
  endfunction

endpackage

// ----- src/bts_stream_if.sv -----
interface bts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bts_col_cell.sv -----
module bts_col_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                clear,
  input  bts_pkg::col_bits_t  d,
  output bts_pkg::col_bits_t  q
);

  bts_pkg::col_bits_t col_r;
  bts_pkg::col_bits_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (advance) begin
      col_nxt = clear ? '0 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign q = col_r;

endmodule

// ----- src/bts_line_store.sv -----
module bts_line_store #(
  parameter int DEPTH = bts_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bts_out_buf.sv -----
module bts_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bts_pkg::out_word_t push_word,
  output logic               full,
  bts_stream_if.source       out_ch
);

  logic               main_v_r;
  logic               main_v_nxt;
  logic               skid_v_r;
  logic               skid_v_nxt;
  bts_pkg::out_word_t main_r;
  bts_pkg::out_word_t main_nxt;
  bts_pkg::out_word_t skid_r;
  bts_pkg::out_word_t skid_nxt;
  logic               pop;

  assign pop = main_v_r && out_ch.ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt = main_r;
    skid_nxt = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt = push_word;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt = push_word;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full = skid_v_r;
  assign out_ch.valid = main_v_r;
  assign out_ch.data = main_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid word held with empty main stage");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into full output buffer");

endmodule

// ----- src/binary_thinning_subpass_unit.sv -----
// channel  | dir | handshake     | word
// in_ch    | in  | valid / ready | kind, pixel
// out_ch   | out | valid / ready | out_valid, out_pixel, out_last, frame_changed
// cfg_*    | in  | cfg_we        | cfg_index selects width, height, sub pass
//
// One input word per cycle while in_ch.ready is high; each word yields one
// output word, registered in the output buffer. The line store read for the next
// column is issued from the column counter's next value, so the stream runs without bubbles.
// in_ch.ready drops in the cycle after each config write and while the
// two-word output buffer is full. rst_n is synchronous and clears counters,
// window and output buffer; the line stores are not cleared.
module binary_thinning_subpass_unit #(
  parameter int MAX_WIDTH = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bts_stream_if.sink                 in_ch,
  bts_stream_if.source               out_ch,
  input  logic                       cfg_we,
  input  logic [bts_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CFG_W = bts_pkg::CFG_W;
  localparam int ROW_W = bts_pkg::ROW_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_EFF = (MAX_WIDTH < bts_pkg::CFG_MAX) ? MAX_WIDTH : bts_pkg::CFG_MAX;
  localparam int H_EFF = (MAX_HEIGHT < bts_pkg::CFG_MAX) ? MAX_HEIGHT : bts_pkg::CFG_MAX;
  localparam int TOT_W = $clog2(W_EFF * H_EFF + 1);
  localparam int CMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             pass_r;
  logic             settle_r;
  logic [TOT_W-1:0] total_r;

  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [TOT_W-1:0] pos_r;
  logic [TOT_W-1:0] pos_nxt;
  logic             any_r;
  logic             any_nxt;

  logic               acc;
  logic               px;
  logic [1:0]         rd_data;
  bts_pkg::col_bits_t new_col;
  bts_pkg::col_bits_t cell_d [bts_pkg::WIN_CELLS];
  bts_pkg::col_bits_t cell_q [bts_pkg::WIN_CELLS];
  logic [8:0]         win;
  logic               pos_valid;
  logic               interior;
  logic               cleared;
  logic               last;
  logic [CMP_W-1:0]   col_plus;
  logic               wrap;
  logic               buf_full;
  bts_pkg::out_word_t res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= bts_pkg::clamp_size(CFG_W'(bts_pkg::RESET_SIZE), MAX_WIDTH);
      height_r <= bts_pkg::clamp_size(CFG_W'(bts_pkg::RESET_SIZE), MAX_HEIGHT);
      pass_r <= 1'b0;
      settle_r <= 1'b0;
    end else begin
      settle_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          bts_pkg::REG_FRAME_WIDTH: begin
            width_r <= bts_pkg::clamp_size(cfg_data, MAX_WIDTH);
          end
          bts_pkg::REG_FRAME_HEIGHT: begin
            height_r <= bts_pkg::clamp_size(cfg_data, MAX_HEIGHT);
          end
          bts_pkg::REG_SUB_PASS: begin
            pass_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TOT_W'(width_r) * TOT_W'(height_r);
  end

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !buf_full && !settle_r;
  assign px = (in_ch.data.kind == bts_pkg::KIND_PIXEL) ? in_ch.data.pixel : 1'b0;

  // rd_data: bit 0 upper line, bit 1 middle line
  assign new_col = {px, rd_data[1], rd_data[0]};
  assign win = {new_col, cell_q[0], cell_q[1]};

  assign pos_valid = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
  assign interior = (col_r >= COL_W'(2)) && (CMP_W'(col_r) < CMP_W'(width_r)) &&
                    (row_r >= ROW_W'(2)) && (row_r < height_r);
  assign cleared = pos_valid && interior && bts_pkg::should_clear(win, pass_r);
  assign last = pos_valid && (({1'b0, pos_r} + 1'b1) >= {1'b0, total_r});
  assign col_plus = CMP_W'(col_r) + 1'b1;
  assign wrap = col_plus >= CMP_W'(width_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    any_nxt = any_r;
    if (acc) begin
      if (wrap) begin
        col_nxt = '0;
        if (row_r != '1) begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_plus[COL_W-1:0];
      end
      if (pos_valid) begin
        if (last) begin
          col_nxt = '0;
          row_nxt = '0;
          pos_nxt = '0;
          any_nxt = 1'b0;
        end else begin
          pos_nxt = pos_r + 1'b1;
          any_nxt = any_r | cleared;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
      any_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
      any_r <= any_nxt;
    end
  end

  bts_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (acc),
    .waddr (col_r),
    .wdata ({px, rd_data[1]}),
    .raddr (col_nxt),
    .rdata (rd_data)
  );

  assign cell_d[0] = new_col;

  for (genvar i = 0; i < bts_pkg::WIN_CELLS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    bts_col_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (acc),
      .clear   (last),
      .d       (cell_d[i]),
      .q       (cell_q[i])
    );
  end

  always_comb begin
    res_word.out_valid = pos_valid;
    res_word.out_pixel = pos_valid && !cleared && win[4];
    res_word.out_last = last;
    res_word.frame_changed = last && (any_r || cleared);
  end

  bts_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_word (res_word),
    .full      (buf_full),
    .out_ch    (out_ch)
  );

  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input taken while frame size settles");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last) |=> ((col_r == '0) && (row_r == '0) && (pos_r == '0) && !any_r))
    else $error("counters not cleared after final pixel");

  a_changed_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.frame_changed) |-> out_ch.data.out_last)
    else $error("frame_changed set off the final pixel");

endmodule

// ----- verif/tb_binary_thinning_subpass_unit.sv -----
`timescale 1ns / 100ps

class subpass_mirror;
  bit [bts_pkg::CFG_W-1:0] width_reg = bts_pkg::CFG_W'(bts_pkg::RESET_SIZE);
  bit [bts_pkg::CFG_W-1:0] height_reg = bts_pkg::CFG_W'(bts_pkg::RESET_SIZE);
  bit pass_sel;
  bit upper_store[bts_pkg::DEF_MAX_WIDTH];
  bit middle_store[bts_pkg::DEF_MAX_WIDTH];
  bit [8:0] win;
  int col;
  int row;
  int out_pos;
  bit any_cleared;
  bts_pkg::out_word_t thinned_q[$];
  int errors;

  function void write_reg(bts_pkg::cfg_reg_t idx, bit [bts_pkg::CFG_W-1:0] val);
    unique case (idx)
      bts_pkg::REG_FRAME_WIDTH: width_reg = val;
      bts_pkg::REG_FRAME_HEIGHT: height_reg = val;
      bts_pkg::REG_SUB_PASS: pass_sel = val[0];
      default: ;
    endcase
  endfunction

  function int span(bit [bts_pkg::CFG_W-1:0] v, int hi);
    if (v < bts_pkg::MIN_SIZE) return bts_pkg::MIN_SIZE;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function int cur_width();
    return span(width_reg, bts_pkg::DEF_MAX_WIDTH);
  endfunction

  function int cur_height();
    return span(height_reg, bts_pkg::DEF_MAX_HEIGHT);
  endfunction

  function bit mid_frame();
    return col != 0 || row != 0;
  endfunction

  function int pending();
    return thinned_q.size();
  endfunction

  function bit thins(bit [8:0] cell_bits, bit pass_one);
    bit [7:0] ring;
    int rises;
    int ones;
    bit prod_a;
    bit prod_b;
    // ring from bit 0: N, NE, E, SE, S, SW, W, NW
    ring = {cell_bits[0], cell_bits[1], cell_bits[2], cell_bits[5],
            cell_bits[8], cell_bits[7], cell_bits[6], cell_bits[3]};
    rises = 0;
    ones = 0;
    for (int k = 0; k < 8; k++) begin
      if (!ring[k] && ring[(k + 1) % 8]) rises++;
      ones += ring[k];
    end
    if (!pass_one) begin
      prod_a = ring[0] & ring[2] & ring[4];
      prod_b = ring[2] & ring[4] & ring[6];
    end else begin
      prod_a = ring[0] & ring[2] & ring[6];
      prod_b = ring[0] & ring[4] & ring[6];
    end
    return cell_bits[4] && rises == 1 && ones >= bts_pkg::MIN_NEIGHBORS &&
           ones <= bts_pkg::MAX_NEIGHBORS && !prod_a && !prod_b;
  endfunction

  function void accept_word(bts_pkg::in_word_t word);
    int w;
    int h;
    bit px;
    bit up;
    bit mid;
    bit valid;
    bit interior;
    bit cleared;
    bts_pkg::out_word_t exp;
    w = cur_width();
    h = cur_height();
    px = (word.kind == bts_pkg::KIND_PIXEL) ? word.pixel : 1'b0;
    up = 1'b0;
    mid = 1'b0;
    if (col < bts_pkg::DEF_MAX_WIDTH) begin
      up = upper_store[col];
      mid = middle_store[col];
      upper_store[col] = mid;
      middle_store[col] = px;
    end
    win = {px, mid, up, win[8:3]};
    valid = (row >= 2) || (row == 1 && col >= 1);
    interior = col >= 2 && col < w && row >= 2 && row <= h - 1;
    cleared = valid && interior && thins(win, pass_sel);
    if (col + 1 >= w) begin
      col = 0;
      if (row < bts_pkg::CFG_MAX) row++;
    end else begin
      col++;
    end
    exp = '0;
    if (valid) begin
      if (cleared) any_cleared = 1'b1;
      exp.out_valid = 1'b1;
      exp.out_pixel = cleared ? 1'b0 : win[4];
      if (out_pos + 1 >= w * h) begin
        exp.out_last = 1'b1;
        exp.frame_changed = any_cleared;
        col = 0;
        row = 0;
        out_pos = 0;
        any_cleared = 1'b0;
        win = '0;
      end else begin
        out_pos++;
      end
    end
    thinned_q.push_back(exp);
  endfunction

  function void check_word(bts_pkg::out_word_t got);
    bts_pkg::out_word_t exp;
    if (thinned_q.size() == 0) begin
      $error("output word %b with nothing expected", got);
      errors++;
      return;
    end
    exp = thinned_q.pop_front();
    if (got.out_valid !== exp.out_valid) begin
      $error("out_valid: expected %b, got %b", exp.out_valid, got.out_valid);
      errors++;
    end
    if (got.out_pixel !== exp.out_pixel) begin
      $error("out_pixel: expected %b, got %b", exp.out_pixel, got.out_pixel);
      errors++;
    end
    if (got.out_last !== exp.out_last) begin
      $error("out_last: expected %b, got %b", exp.out_last, got.out_last);
      errors++;
    end
    if (got.frame_changed !== exp.frame_changed) begin
      $error("frame_changed: expected %b, got %b", exp.frame_changed, got.frame_changed);
      errors++;
    end
  endfunction
endclass

module tb_binary_thinning_subpass_unit;

  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int RANDOM_ITEMS = 520;
  localparam int HOLD_AFTER_WORDS = 400;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bts_pkg::IDX_W-1:0] cfg_index;
  logic [bts_pkg::CFG_W-1:0] cfg_data;

  bts_stream_if #(.payload_t(bts_pkg::in_word_t)) in_ch ();
  bts_stream_if #(.payload_t(bts_pkg::out_word_t)) out_ch ();

  subpass_mirror sb;
  int cycles = 0;
  int out_words = 0;
  int items_sent = 0;
  int send_run = 0;
  int take_run = 0;
  bit held_off = 1'b0;

  binary_thinning_subpass_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_binary_thinning_subpass_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.accept_word(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.data);
      out_words <= out_words + 1;
    end
  end

  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) run_left = $urandom_range(15, 60);
    return $urandom_range(0, 12);
  endfunction

  initial begin : take_side
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && out_words >= HOLD_AFTER_WORDS) begin
        // hold off long enough to back up the input
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = draw_gap(take_run);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_word(logic word_kind, logic word_pixel);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {word_kind, word_pixel};
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic program_regs(int width_val, int height_val, int pass_val);
    bts_pkg::cfg_reg_t order[3];
    int vals[3];
    wait_idle();
    order = '{bts_pkg::REG_FRAME_WIDTH, bts_pkg::REG_FRAME_HEIGHT, bts_pkg::REG_SUB_PASS};
    vals = '{width_val, height_val, pass_val};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= bts_pkg::CFG_W'(vals[i]);
      sb.write_reg(order[i], bts_pkg::CFG_W'(vals[i]));
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(int density);
    int w;
    int h;
    w = sb.cur_width();
    h = sb.cur_height();
    for (int i = 0; i < w * h; i++) begin
      send_word(bts_pkg::KIND_PIXEL, $urandom_range(0, 3) < density);
    end
    for (int i = 0; i <= w; i++) send_word(bts_pkg::KIND_FLUSH, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(4, sb.cur_width() * sb.cur_height() + sb.cur_width());
    repeat (n) begin
      send_word(($urandom_range(0, 5) == 0) ? bts_pkg::KIND_FLUSH : bts_pkg::KIND_PIXEL,
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic finish_frame();
    while (sb.mid_frame()) begin
      send_word((sb.row < sb.cur_height()) ? bts_pkg::KIND_PIXEL : bts_pkg::KIND_FLUSH,
                1'($urandom_range(0, 1)));
    end
  endtask

  function automatic int pick_size();
    unique case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(10, 16);
      default: return $urandom_range(4, 9);
    endcase
  endfunction

  initial begin
    logic [15:0] square;
    int start_items;
    sb = new;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = bts_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    program_regs(4, 4, 0);
    square = 16'b0000_0110_0110_0000;
    for (int i = 0; i < 16; i++) send_word(bts_pkg::KIND_PIXEL, square[15 - i]);
    send_word(bts_pkg::KIND_FLUSH, 1'b0);
    send_word(bts_pkg::KIND_FLUSH, 1'b1);
    send_word(bts_pkg::KIND_FLUSH, 1'b0);
    send_word(bts_pkg::KIND_FLUSH, 1'b1);
    send_word(bts_pkg::KIND_FLUSH, 1'b1);
    // drive past the drain into a new frame
    send_word(bts_pkg::KIND_PIXEL, 1'b1);
    send_word(bts_pkg::KIND_PIXEL, 1'b1);
    program_regs(4, 0, 1);
    finish_frame();

    // oversized width, then shrink the frame part way through a row
    program_regs(bts_pkg::CFG_MAX, 3, 0);
    repeat (40) send_word(bts_pkg::KIND_PIXEL, 1'($urandom_range(0, 1)));
    program_regs(4, 4, 1);
    finish_frame();
    // oversized height, then shrink below the count already sent
    program_regs(0, bts_pkg::CFG_MAX, 1);
    repeat (30) send_word(bts_pkg::KIND_PIXEL, 1'($urandom_range(0, 1)));
    program_regs(5, 4, 0);
    finish_frame();

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      program_regs(pick_size(), pick_size(), $urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) finish_frame();
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 3) != 0) send_frame($urandom_range(1, 3));
        else send_noise();
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_binary_thinning_subpass_unit: PASS");
    end else begin
      $display("tb_binary_thinning_subpass_unit: FAIL");
    end
    $finish;
  end
endmodule

// ----- binary_thinning_subpass_unit.f -----
src/bts_pkg.sv
src/bts_stream_if.sv
src/bts_col_cell.sv
src/bts_line_store.sv
src/bts_out_buf.sv
src/binary_thinning_subpass_unit.sv
verif/tb_binary_thinning_subpass_unit.sv
